// ----- sv/bqc_pkg.sv -----
// Shared types and constants for the billboard quad corner generator.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package bqc_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int VIEW_W        = 34;
    localparam int MAG_W         = 33;
    localparam int QUEUE_DEPTH   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X  = 3'd0,
        CFG_CENTER_Y  = 3'd1,
        CFG_CENTER_Z  = 3'd2,
        CFG_HALF_SIZE = 3'd3,
        CFG_EYE_DROP  = 3'd4
    } cfg_idx_e;

    typedef struct packed {
        logic signed [VIEW_W-1:0] a;
        logic signed [VIEW_W-1:0] b;
        logic signed [VIEW_W-1:0] c;
    } view_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCALE, ST_NORM, ST_SQ0, ST_SQ1, ST_SUM, ST_SQRT,
        ST_DINIT, ST_DIV, ST_VX, ST_VZ, ST_VFIN, ST_CMUL, ST_CADD, ST_EMIT
    } back_state_t;

    typedef enum logic [1:0] {
        PH_LEN, PH_N1, PH_N2
    } root_phase_t;

    typedef enum logic [1:0] {
        DQ_UA = 2'd0,
        DQ_UC = 2'd1,
        DQ_P  = 2'd2,
        DQ_Q  = 2'd3
    } div_sel_t;

endpackage

// ----- sv/bqc_front.sv -----
// Front stage: accepts camera beats and forms the view vector a, b, c.
// Depends on bqc_pkg.
`timescale 1ns / 1ps

module bqc_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [31:0]   s_camera_x,
    input  logic signed [31:0]   s_camera_y,
    input  logic signed [31:0]   s_camera_z,
    input  logic signed [31:0]   center_x,
    input  logic signed [31:0]   center_y,
    input  logic signed [31:0]   center_z,
    input  logic signed [31:0]   eye_drop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output bqc_pkg::view_t       out_view
);
    import bqc_pkg::*;

    logic  valid_reg;
    view_t view_reg;
    view_t view_next;

    function automatic logic signed [VIEW_W-1:0] sx(input logic signed [31:0] x);
        return {{(VIEW_W-32){x[31]}}, x};
    endfunction

    always_comb begin
        view_next.a = sx(center_x) - sx(s_camera_x);
        view_next.b = sx(center_y) - sx(s_camera_y) - sx(eye_drop);
        view_next.c = sx(center_z) - sx(s_camera_z);
    end

    assign s_ready   = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_view  = view_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            view_reg <= view_next;
        end
    end

endmodule

// ----- sv/bqc_fifo.sv -----
// Short queue of view vectors between the front and back stages.
// Depends on bqc_pkg.
`timescale 1ns / 1ps

module bqc_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  bqc_pkg::view_t in_view,
    output logic           out_valid,
    input  logic           out_ready,
    output bqc_pkg::view_t out_view
);
    import bqc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    view_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_view  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_view;
        end
    end

endmodule

// ----- sv/bqc_back.sv -----
// Back stage: scales the view vector, builds the two unit basis vectors unless
// the view is degenerate, using a shared root, divide and multiply unit, and
// emits four corner beats. Depends on bqc_pkg.
`timescale 1ns / 1ps

module bqc_back #(
    parameter int FRACTION_BITS = bqc_pkg::FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bqc_pkg::view_t       in_view,
    input  logic signed [31:0]   center_x,
    input  logic signed [31:0]   center_y,
    input  logic signed [31:0]   center_z,
    input  logic [30:0]          half_size,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [31:0]   m_vertex_x,
    output logic signed [31:0]   m_vertex_y,
    output logic signed [31:0]   m_vertex_z,
    output logic [1:0]           m_corner_index,
    output logic                 m_last_corner,
    output logic                 m_degenerate
);
    import bqc_pkg::*;

    localparam int F   = FRACTION_BITS;
    localparam int QW  = F + 2;
    localparam int DVW = F + 33;
    localparam int DW  = F + 4;
    localparam int CW  = $clog2(QW);

    back_state_t state_reg, state_next;

    logic [MAG_W-1:0] ma_reg, mb_reg, mc_reg;
    logic             sa_reg, sb_reg, sc_reg;
    logic             degen_reg;
    root_phase_t      phase_reg;
    div_sel_t         dsel_reg;
    logic [31:0]      u_reg, w_reg, len_reg, n_reg;
    logic [63:0]      prod_reg, acc_reg, s_reg, r_reg, bit_reg;
    logic [31:0]      rem_reg;
    logic [QW-1:0]    dq_reg;
    logic [CW-1:0]    cnt_reg;
    logic [QW-1:0]    ua_reg, uc_reg, p_reg, q_reg, vxm_reg, vzm_reg;
    logic             dneg_reg;
    logic [1:0]       axis_reg;
    logic [1:0]       k_reg;
    logic signed [31:0] vx_reg, vy_reg, vz_reg;

    // Scaling decisions.
    logic [MAG_W-1:0] m_ab, m_max;
    logic             halve, dbl, degen_now, norm_dbl;
    assign m_ab      = (ma_reg > mb_reg) ? ma_reg : mb_reg;
    assign m_max     = (m_ab > mc_reg) ? m_ab : mc_reg;
    assign halve     = m_max[32] || m_max[31];
    assign dbl       = !halve && (m_max != '0) && !m_max[30];
    assign degen_now = ((ma_reg == '0) && (mc_reg == '0)) || (mb_reg == '0);
    assign norm_dbl  = !(u_reg[31] || u_reg[30] || w_reg[31] || w_reg[30]);

    // Square-root step.
    logic [63:0] trial, s_step, r_step;
    logic        sq_ge;
    assign trial  = r_reg + bit_reg;
    assign sq_ge  = (s_reg >= trial);
    assign s_step = sq_ge ? (s_reg - trial) : s_reg;
    assign r_step = sq_ge ? ((r_reg >> 1) + bit_reg) : (r_reg >> 1);

    // Division step.
    logic [31:0]    div_m;
    logic [DVW-1:0] dividend;
    logic [32:0]    rem2, rem_sub;
    logic           dv_ge;
    logic [QW-1:0]  dq_step;
    assign div_m    = dsel_reg[0] ? w_reg : u_reg;
    assign dividend = {1'b0, div_m, {F{1'b0}}} + DVW'(n_reg >> 1);
    assign rem2     = {rem_reg, dq_reg[QW-1]};
    assign dv_ge    = (rem2 >= {1'b0, n_reg});
    assign rem_sub  = dv_ge ? (rem2 - {1'b0, n_reg}) : rem2;
    assign dq_step  = {dq_reg[QW-2:0], dv_ge};

    // Basis vectors as signed values and the corner direction.
    logic signed [DW-1:0] ua_w, uc_w, p_w, vxm_w, vzm_w;
    logic signed [DW-1:0] hx, hz, vx, vz, dx, dy, dz, dir;
    logic                 sh_pos, sv_pos, vx_neg, vz_neg;
    logic [DW-1:0]        dir_mag;
    assign ua_w   = signed'(DW'(ua_reg));
    assign uc_w   = signed'(DW'(uc_reg));
    assign p_w    = signed'(DW'(p_reg));
    assign vxm_w  = signed'(DW'(vxm_reg));
    assign vzm_w  = signed'(DW'(vzm_reg));
    assign vx_neg = !(sa_reg ^ sb_reg);
    assign vz_neg = (!sc_reg) ^ sb_reg;
    assign hx     = sc_reg ? uc_w : -uc_w;
    assign hz     = sa_reg ? -ua_w : ua_w;
    assign vx     = vx_neg ? -vxm_w : vxm_w;
    assign vz     = vz_neg ? -vzm_w : vzm_w;
    assign sh_pos = !k_reg[1];
    assign sv_pos = (k_reg == 2'd1) || (k_reg == 2'd2);
    assign dx     = (sh_pos ? hx : -hx) + (sv_pos ? vx : -vx);
    assign dy     = sv_pos ? p_w : -p_w;
    assign dz     = (sh_pos ? hz : -hz) + (sv_pos ? vz : -vz);

    always_comb begin
        case (axis_reg)
            2'd0:    dir = dx;
            2'd1:    dir = dy;
            default: dir = dz;
        endcase
    end
    assign dir_mag = dir[DW-1] ? DW'(-dir) : DW'(dir);

    // Shared multiplier, registered.
    logic [31:0] mul_a, mul_b;
    logic [31:0] sq_u, sq_w;
    logic [63:0] mul_p;
    assign sq_u = (phase_reg == PH_LEN) ? ma_reg[31:0] : u_reg;
    assign sq_w = (phase_reg == PH_LEN) ? mc_reg[31:0] : w_reg;

    always_comb begin
        case (state_reg)
            ST_SQ0: begin
                mul_a = sq_u;
                mul_b = sq_u;
            end
            ST_SQ1: begin
                mul_a = sq_w;
                mul_b = sq_w;
            end
            ST_VX: begin
                mul_a = 32'(ua_reg);
                mul_b = 32'(q_reg);
            end
            ST_VZ: begin
                mul_a = 32'(uc_reg);
                mul_b = 32'(q_reg);
            end
            ST_CMUL: begin
                mul_a = {1'b0, half_size};
                mul_b = 32'(dir_mag);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Rounding and saturation of a corner coordinate.
    logic [63:0]        rnd;
    logic [33:0]        pm;
    logic signed [31:0] cen;
    logic signed [35:0] sum;
    logic signed [31:0] sat;
    assign rnd = prod_reg + (64'd1 << (F - 1));
    assign pm  = rnd[F+33:F];

    always_comb begin
        case (axis_reg)
            2'd0:    cen = center_x;
            2'd1:    cen = center_y;
            default: cen = center_z;
        endcase
    end

    assign sum = {{4{cen[31]}}, cen} +
                 (dneg_reg ? -signed'({2'b0, pm}) : signed'({2'b0, pm}));

    always_comb begin
        if (sum > 36'sd2147483647) begin
            sat = 32'sh7fffffff;
        end else if (sum < -36'sd2147483648) begin
            sat = 32'sh80000000;
        end else begin
            sat = sum[31:0];
        end
    end

    // Next state and handshake outputs.
    always_comb begin
        state_next = state_reg;
        in_ready   = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                if (!halve && !dbl) begin
                    state_next = degen_now ? ST_EMIT : ST_SQ0;
                end
            end
            ST_NORM: begin
                if (!norm_dbl) begin
                    state_next = ST_SQ0;
                end
            end
            ST_SQ0:  state_next = ST_SQ1;
            ST_SQ1:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_SQRT;
            ST_SQRT: begin
                if (bit_reg[0]) begin
                    state_next = (phase_reg == PH_LEN) ? ST_NORM : ST_DINIT;
                end
            end
            ST_DINIT: state_next = ST_DIV;
            ST_DIV: begin
                if (cnt_reg == CW'(QW - 1)) begin
                    unique case (dsel_reg)
                        DQ_UA:   state_next = ST_DINIT;
                        DQ_UC:   state_next = ST_NORM;
                        DQ_P:    state_next = ST_DINIT;
                        default: state_next = ST_VX;
                    endcase
                end
            end
            ST_VX:   state_next = ST_VZ;
            ST_VZ:   state_next = ST_VFIN;
            ST_VFIN: state_next = ST_CMUL;
            ST_CMUL: state_next = ST_CADD;
            ST_CADD: begin
                if (axis_reg == 2'd2) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_CMUL;
                end
            end
            ST_EMIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (k_reg == 2'd3) begin
                        state_next = ST_IDLE;
                    end else if (degen_reg) begin
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_CMUL;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath.
    always_ff @(posedge aclk) begin
        prod_reg <= mul_p;
        case (state_reg)
            ST_IDLE: begin
                sa_reg    <= in_view.a[VIEW_W-1];
                sb_reg    <= in_view.b[VIEW_W-1];
                sc_reg    <= in_view.c[VIEW_W-1];
                ma_reg    <= in_view.a[VIEW_W-1] ? MAG_W'(-in_view.a) : MAG_W'(in_view.a);
                mb_reg    <= in_view.b[VIEW_W-1] ? MAG_W'(-in_view.b) : MAG_W'(in_view.b);
                mc_reg    <= in_view.c[VIEW_W-1] ? MAG_W'(-in_view.c) : MAG_W'(in_view.c);
                phase_reg <= PH_LEN;
                k_reg     <= 2'd0;
                axis_reg  <= 2'd0;
            end
            ST_SCALE: begin
                if (halve) begin
                    ma_reg <= ma_reg >> 1;
                    mb_reg <= mb_reg >> 1;
                    mc_reg <= mc_reg >> 1;
                end else if (dbl) begin
                    ma_reg <= ma_reg << 1;
                    mb_reg <= mb_reg << 1;
                    mc_reg <= mc_reg << 1;
                end else begin
                    degen_reg <= degen_now;
                    vx_reg    <= center_x;
                    vy_reg    <= center_y;
                    vz_reg    <= center_z;
                end
            end
            ST_NORM: begin
                if (norm_dbl) begin
                    u_reg <= u_reg << 1;
                    w_reg <= w_reg << 1;
                end
            end
            ST_SQ1: acc_reg <= prod_reg;
            ST_SUM: begin
                s_reg   <= acc_reg + prod_reg;
                r_reg   <= '0;
                bit_reg <= 64'd1 << 62;
            end
            ST_SQRT: begin
                s_reg   <= s_step;
                r_reg   <= r_step;
                bit_reg <= bit_reg >> 2;
                if (bit_reg[0]) begin
                    case (phase_reg)
                        PH_LEN: begin
                            len_reg   <= r_step[31:0];
                            u_reg     <= ma_reg[31:0];
                            w_reg     <= mc_reg[31:0];
                            phase_reg <= PH_N1;
                        end
                        PH_N1: begin
                            n_reg    <= r_step[31:0];
                            dsel_reg <= DQ_UA;
                        end
                        default: begin
                            n_reg    <= r_step[31:0];
                            dsel_reg <= DQ_P;
                        end
                    endcase
                end
            end
            ST_DINIT: begin
                rem_reg <= 32'(dividend[DVW-1:QW]);
                dq_reg  <= dividend[QW-1:0];
                cnt_reg <= '0;
            end
            ST_DIV: begin
                rem_reg <= rem_sub[31:0];
                dq_reg  <= dq_step;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(QW - 1)) begin
                    case (dsel_reg)
                        DQ_UA: begin
                            ua_reg   <= dq_step;
                            dsel_reg <= DQ_UC;
                        end
                        DQ_UC: begin
                            uc_reg    <= dq_step;
                            u_reg     <= len_reg;
                            w_reg     <= mb_reg[31:0];
                            phase_reg <= PH_N2;
                        end
                        DQ_P: begin
                            p_reg    <= dq_step;
                            dsel_reg <= DQ_Q;
                        end
                        default: q_reg <= dq_step;
                    endcase
                end
            end
            ST_VZ:   vxm_reg <= rnd[F+QW-1:F];
            ST_VFIN: begin
                vzm_reg  <= rnd[F+QW-1:F];
                axis_reg <= 2'd0;
            end
            ST_CMUL: dneg_reg <= dir[DW-1];
            ST_CADD: begin
                case (axis_reg)
                    2'd0:    vx_reg <= sat;
                    2'd1:    vy_reg <= sat;
                    default: vz_reg <= sat;
                endcase
                axis_reg <= (axis_reg == 2'd2) ? 2'd0 : axis_reg + 2'd1;
            end
            ST_EMIT: begin
                if (m_ready) begin
                    k_reg    <= k_reg + 2'd1;
                    axis_reg <= 2'd0;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_vertex_x     = vx_reg;
    assign m_vertex_y     = vy_reg;
    assign m_vertex_z     = vz_reg;
    assign m_corner_index = k_reg;
    assign m_last_corner  = (k_reg == 2'd3);
    assign m_degenerate   = degen_reg;

endmodule

// ----- sv/billboard_quad_corners.sv -----
// A camera beat passes through the front stage and queue, then the back stage to corner 0;
// the back-stage pass is longer when the view vector or its horizontal part needs many
// doubling steps, and shorter for degenerate views.
// Throughput: one camera beat per back-stage pass plus result stalls; the shared root and
// divide unit sets it.
// Reset: synchronous, active-low aresetn; registers return to center (50,30,0), half 3, drop 10.
`timescale 1ns / 1ps

module billboard_quad_corners #(
    parameter int FRACTION_BITS = bqc_pkg::FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [31:0]               s_camera_x,
    input  logic signed [31:0]               s_camera_y,
    input  logic signed [31:0]               s_camera_z,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [31:0]               m_vertex_x,
    output logic signed [31:0]               m_vertex_y,
    output logic signed [31:0]               m_vertex_z,
    output logic [1:0]                       m_corner_index,
    output logic                             m_last_corner,
    output logic                             m_degenerate,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bqc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                      cfg_data
);
    import bqc_pkg::*;

    // The configuration registers are always writable. Writes are expected only
    // while no camera beat is in flight, so the datapath reads them directly.
    logic signed [31:0] center_x_reg, center_y_reg, center_z_reg, eye_drop_reg;
    logic [30:0]        half_size_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg  <= 32'sd3276800;
            center_y_reg  <= 32'sd1966080;
            center_z_reg  <= 32'sd0;
            half_size_reg <= 31'd196608;
            eye_drop_reg  <= 32'sd655360;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_CENTER_X:  center_x_reg  <= cfg_data;
                CFG_CENTER_Y:  center_y_reg  <= cfg_data;
                CFG_CENTER_Z:  center_z_reg  <= cfg_data;
                CFG_HALF_SIZE: half_size_reg <= cfg_data[30:0];
                CFG_EYE_DROP:  eye_drop_reg  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The front stage forms and registers the view vector and hands it to a
    // two-entry queue, so new camera beats are taken while the back stage
    // is still working on an earlier one or waiting on the result channel.
    logic  fr_valid, fr_ready, bk_valid, bk_ready;
    view_t fr_view, bk_view;

    bqc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_camera_x (s_camera_x),
        .s_camera_y (s_camera_y),
        .s_camera_z (s_camera_z),
        .center_x   (center_x_reg),
        .center_y   (center_y_reg),
        .center_z   (center_z_reg),
        .eye_drop   (eye_drop_reg),
        .out_valid  (fr_valid),
        .out_ready  (fr_ready),
        .out_view   (fr_view)
    );

    bqc_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_view   (fr_view),
        .out_valid (bk_valid),
        .out_ready (bk_ready),
        .out_view  (bk_view)
    );

    // The back stage scales the vector, takes three integer square roots and
    // four restoring divisions on one shared unit, then builds each corner
    // coordinate with one multiply and a rounded, saturating add.
    bqc_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (bk_valid),
        .in_ready       (bk_ready),
        .in_view        (bk_view),
        .center_x       (center_x_reg),
        .center_y       (center_y_reg),
        .center_z       (center_z_reg),
        .half_size      (half_size_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_vertex_x     (m_vertex_x),
        .m_vertex_y     (m_vertex_y),
        .m_vertex_z     (m_vertex_z),
        .m_corner_index (m_corner_index),
        .m_last_corner  (m_last_corner),
        .m_degenerate   (m_degenerate)
    );

    // A degenerate quad always sits on the configured center.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |->
            (m_vertex_x == center_x_reg) && (m_vertex_y == center_y_reg) &&
            (m_vertex_z == center_z_reg))
        else $error("degenerate corner differs from center");

    // Corners of a quad are numbered in order from beat to beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_corner |=>
            m_corner_index == $past(m_corner_index) + 2'd1)
        else $error("corner index did not advance");

    // All four beats of one quad carry the same degenerate flag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_corner |=>
            m_degenerate == $past(m_degenerate))
        else $error("degenerate flag changed inside a quad");

endmodule
